// ===== hw/rtl/m3h_pkg.sv =====
// Shared constants, types and helpers for the MurmurHash3 x86_32 core.
`default_nettype none
package m3h_pkg;

    localparam logic [31:0] C1 = 32'hcc9e2d51;
    localparam logic [31:0] C2 = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] F1 = 32'h85ebca6b;
    localparam logic [31:0] F2 = 32'hc2b2ae35;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic        do_mix;
        logic        do_final;
        logic        load;
        logic [31:0] seed;
        logic [31:0] word;
        logic [23:0] tail;
        logic [1:0]  tail_cnt;
        logic [31:0] length;
    } m3h_job_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX_A,
        ST_MIX_B,
        ST_MIX_C,
        ST_TAIL_A,
        ST_TAIL_B,
        ST_FIN_A,
        ST_FIN_B,
        ST_FIN_C
    } m3h_state_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/m3h_front.sv =====
// Front end: takes byte beats, packs words, tracks length and seed, issues jobs.
`default_nettype none
module m3h_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [31:0]      cfg_wdata,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [7:0]       s_data_byte,
    input  wire logic             s_byte_valid,
    input  wire logic             s_last,
    input  wire logic             q_full,
    output logic                  q_push,
    output m3h_pkg::m3h_job_t     q_job
);
    import m3h_pkg::*;

    logic [31:0] seed_reg, seed_next;
    logic [31:0] msg_seed_reg, msg_seed_next;
    logic        pend_load_reg, pend_load_next;
    logic [23:0] buf_reg, buf_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [31:0] len_reg, len_next;

    logic        accept;
    logic        mix;
    logic [31:0] word;
    logic [23:0] buf_acc;
    logic [1:0]  cnt_acc;
    logic [31:0] len_acc;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        buf_acc = buf_reg;
        cnt_acc = cnt_reg;
        len_acc = len_reg;
        mix     = 1'b0;
        word    = {8'd0, buf_reg};
        if (s_byte_valid) begin
            len_acc = len_reg + 32'd1;
            case (cnt_reg)
                2'd0: begin
                    buf_acc[7:0] = s_data_byte;
                    cnt_acc      = 2'd1;
                end
                2'd1: begin
                    buf_acc[15:8] = s_data_byte;
                    cnt_acc       = 2'd2;
                end
                2'd2: begin
                    buf_acc[23:16] = s_data_byte;
                    cnt_acc        = 2'd3;
                end
                default: begin
                    word    = {s_data_byte, buf_reg};
                    mix     = 1'b1;
                    buf_acc = '0;
                    cnt_acc = 2'd0;
                end
            endcase
        end

        q_push         = accept && (mix || s_last);
        q_job.do_mix   = mix;
        q_job.do_final = s_last;
        q_job.load     = pend_load_reg;
        q_job.seed     = msg_seed_reg;
        q_job.word     = word;
        q_job.tail     = buf_acc;
        q_job.tail_cnt = cnt_acc;
        q_job.length   = len_acc;

        seed_next      = seed_reg;
        msg_seed_next  = msg_seed_reg;
        pend_load_next = pend_load_reg;
        buf_next       = buf_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;

        if (accept) begin
            if (s_last) begin
                buf_next       = '0;
                cnt_next       = 2'd0;
                len_next       = '0;
                msg_seed_next  = seed_reg;
                pend_load_next = 1'b1;
            end else begin
                buf_next = buf_acc;
                cnt_next = cnt_acc;
                len_next = len_acc;
                if (mix) begin
                    pend_load_next = 1'b0;
                end
            end
        end

        if (cfg_we) begin
            seed_next = cfg_wdata;
            if (len_reg == 32'd0 && cnt_reg == 2'd0) begin
                msg_seed_next  = cfg_wdata;
                pend_load_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg      <= '0;
            msg_seed_reg  <= '0;
            pend_load_reg <= 1'b1;
            buf_reg       <= '0;
            cnt_reg       <= 2'd0;
            len_reg       <= '0;
        end else begin
            seed_reg      <= seed_next;
            msg_seed_reg  <= msg_seed_next;
            pend_load_reg <= pend_load_next;
            buf_reg       <= buf_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/m3h_queue.sv =====
// Small job queue between front and back ends.
`default_nettype none
module m3h_queue #(
    parameter int DEPTH = m3h_pkg::QUEUE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire m3h_pkg::m3h_job_t push_job,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output m3h_pkg::m3h_job_t      pop_job
);
    import m3h_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    m3h_job_t      entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign pop_job   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/m3h_back.sv =====
// Back end: word mixing, tail fold and fmix32 on one shared multiplier.
`default_nettype none
module m3h_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_not_empty,
    input  wire m3h_pkg::m3h_job_t q_job,
    output logic                   q_pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [31:0]            m_hash_value
);
    import m3h_pkg::*;

    m3h_state_t  state_reg, state_next;
    m3h_job_t    job_reg, job_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] prod_reg, prod_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_hash_reg, out_hash_next;

    logic [31:0] mul_a, mul_b, mul_p;
    logic [31:0] hx, fx, gx;
    logic        out_free;

    assign mul_p    = mul_a * mul_b;
    assign out_free = !out_valid_reg || m_ready;
    assign hx       = rotl32(h_reg ^ prod_reg, 13);
    assign fx       = h_reg ^ ((job_reg.tail_cnt != 2'd0) ? prod_reg : 32'd0)
                      ^ job_reg.length;
    assign gx       = prod_reg ^ (prod_reg >> 13);

    always_comb begin
        state_next     = state_reg;
        job_next       = job_reg;
        h_next         = h_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg;
        out_hash_next  = out_hash_reg;
        q_pop          = 1'b0;
        mul_a          = '0;
        mul_b          = '0;

        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_not_empty) begin
                    q_pop    = 1'b1;
                    job_next = q_job;
                    if (q_job.load) begin
                        h_next = q_job.seed;
                    end
                    state_next = q_job.do_mix ? ST_MIX_A : ST_TAIL_A;
                end
            end
            ST_MIX_A: begin
                mul_a      = job_reg.word;
                mul_b      = C1;
                prod_next  = mul_p;
                state_next = ST_MIX_B;
            end
            ST_MIX_B: begin
                mul_a      = rotl32(prod_reg, 15);
                mul_b      = C2;
                prod_next  = mul_p;
                state_next = ST_MIX_C;
            end
            ST_MIX_C: begin
                h_next     = (hx << 2) + hx + MIX_ADD;
                state_next = job_reg.do_final ? ST_TAIL_A : ST_IDLE;
            end
            ST_TAIL_A: begin
                mul_a      = {8'd0, job_reg.tail};
                mul_b      = C1;
                prod_next  = mul_p;
                state_next = ST_TAIL_B;
            end
            ST_TAIL_B: begin
                mul_a      = rotl32(prod_reg, 15);
                mul_b      = C2;
                prod_next  = mul_p;
                state_next = ST_FIN_A;
            end
            ST_FIN_A: begin
                mul_a      = fx ^ (fx >> 16);
                mul_b      = F1;
                prod_next  = mul_p;
                state_next = ST_FIN_B;
            end
            ST_FIN_B: begin
                mul_a      = gx;
                mul_b      = F2;
                prod_next  = mul_p;
                state_next = ST_FIN_C;
            end
            ST_FIN_C: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_hash_next  = prod_reg ^ (prod_reg >> 16);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg      <= job_next;
        h_reg        <= h_next;
        prod_reg     <= prod_next;
        out_hash_reg <= out_hash_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_hash_value = out_hash_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/murmur3_32_string_hash_core.sv =====
// Top level of the streaming MurmurHash3 x86_32 byte hasher.
//
// Input channel (s_*): one byte beat per cycle with s_byte_valid and s_last.
// A beat with s_last and no byte closes an empty message; a beat with
// neither flag is dropped. Result channel (m_*): one hash beat per message.
// cfg_we/cfg_wdata write the seed; it applies from the next message start,
// or at once while the current message has taken no bytes.
//
// The front end packs bytes and takes one beat per cycle while the job
// queue has room. On one shared 32x32 multiplier the back end handles a
// full word as queue pop, two multiplies and hash update, a message end
// as pop, tail scramble and fmix32, and both in turn when the last beat
// also completes a word. Long messages run at one byte a cycle while
// results are taken; short messages are bounded by the per-message cost.
// m_valid rises once the job of the last beat has left the queue and run
// through the back end, behind any work still ahead of it there. Queue
// depth is QUEUE_DEPTH jobs.
//
// Reset clears seed to 0 and empties the queue and the output register.
// When m_ready is low the result holds in the output register; the back
// end halts at the next message end and the queue fills, then s_ready drops.
`default_nettype none
module murmur3_32_string_hash_core #(
    parameter int QUEUE_DEPTH = m3h_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_byte_valid,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_hash_value
);
    import m3h_pkg::*;

    logic     q_full;
    logic     q_push;
    m3h_job_t q_in_job;
    logic     q_not_empty;
    logic     q_pop;
    m3h_job_t q_out_job;

    m3h_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_byte_valid (s_byte_valid),
        .s_last       (s_last),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (q_in_job)
    );

    m3h_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (q_in_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_job   (q_out_job)
    );

    m3h_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_not_empty  (q_not_empty),
        .q_job        (q_out_job),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the streaming MurmurHash3 x86_32 byte hasher core.
module tb;

    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] FMIX_M1 = 32'h85ebca6b;
    localparam logic [31:0] FMIX_M2 = 32'hc2b2ae35;

    localparam int CLK_HALF      = 4;
    localparam int MAX_GAP       = 13;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_BEATS  = 650;
    localparam int HOLD_CYCLES   = 300;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_byte_valid;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_hash_value;

    // expected-hash state
    logic [31:0] seed_value;
    logic [31:0] acc_hash;
    logic [23:0] tail_bytes;
    logic [1:0]  tail_count;
    logic [31:0] byte_count;
    logic [31:0] expected_hashes[$];

    int mismatch_count = 0;
    bit src_no_gaps;
    bit sink_no_gaps;
    int sink_hold_cycles;

    always #(CLK_HALF) aclk = ~aclk;

    murmur3_32_string_hash_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_byte_valid (s_byte_valid),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
        logic [63:0] twice;
        twice = {x, x} << r;
        return twice[63:32];
    endfunction

    function automatic logic [31:0] scramble_word(input logic [31:0] k);
        logic [31:0] t;
        t = k * MIX_C1;
        t = rotl(t, 15);
        return t * MIX_C2;
    endfunction

    function automatic logic [31:0] avalanche(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * FMIX_M1;
        t = t ^ (t >> 13);
        t = t * FMIX_M2;
        return t ^ (t >> 16);
    endfunction

    task automatic restart_message();
        acc_hash   = seed_value;
        tail_bytes = '0;
        tail_count = '0;
        byte_count = '0;
    endtask

    task automatic predict_beat(input logic [7:0] d, input logic bv, input logic lst);
        logic [31:0] h;
        if (bv) begin
            byte_count = byte_count + 32'd1;
            if (tail_count == 2'd3) begin
                acc_hash   = acc_hash ^ scramble_word({d, tail_bytes});
                acc_hash   = rotl(acc_hash, 13) * 32'd5 + MIX_ADD;
                tail_bytes = '0;
                tail_count = '0;
            end else begin
                tail_bytes[8 * tail_count +: 8] = d;
                tail_count = tail_count + 2'd1;
            end
        end
        if (lst) begin
            h = acc_hash;
            if (tail_count != 2'd0)
                h = h ^ scramble_word({8'h00, tail_bytes});
            h = h ^ byte_count;
            expected_hashes.push_back(avalanche(h));
            restart_message();
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic send_beat(input logic [7:0] d, input logic bv, input logic lst);
        int gap;
        gap = src_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= d;
        s_byte_valid <= bv;
        s_last       <= lst;
        do @(posedge aclk); while (!s_ready);
        predict_beat(d, bv, lst);
    endtask

    // returns the number of beats that were not simply dropped
    task automatic send_message(input int len, input bit marker_end, output int beats);
        beats = 0;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_beat(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !marker_end);
            beats++;
        end
        if (len == 0 || marker_end) begin
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            beats++;
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (expected_hashes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        seed_value = v;
        if (byte_count == 32'd0 && tail_count == 2'd0)
            acc_hash = v;
        @(posedge aclk);
    endtask

    task automatic test_empty_message();
        send_beat(8'h5a, 1'b0, 1'b1);
    endtask

    task automatic test_short_lengths();
        for (int len = 1; len <= 5; len++)
            for (int i = 0; i < len; i++)
                send_beat((len % 2) ? 8'hff : ((i % 2) ? 8'h80 : 8'h01), 1'b1, i == len - 1);
    endtask

    task automatic test_ignored_beats();
        send_beat(8'ha5, 1'b0, 1'b0);
        send_beat(8'h3c, 1'b1, 1'b0);
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'hc3, 1'b1, 1'b0);
        send_beat(8'hff, 1'b0, 1'b1);
    endtask

    task automatic test_seed_update();
        settle();
        write_seed(32'hffff_ffff);
        send_beat(8'h12, 1'b1, 1'b0);
        send_beat(8'h34, 1'b1, 1'b0);
        settle();
        // bytes pending, so the new seed waits for the next message
        write_seed(32'h0000_0000);
        send_beat(8'h56, 1'b1, 1'b1);
        send_beat(8'h00, 1'b0, 1'b0);
        settle();
        write_seed(32'h8000_0001);
        send_beat(8'hff, 1'b0, 1'b1);
    endtask

    task automatic test_backpressure();
        int beats;
        settle();
        write_seed($urandom);
        sink_hold_cycles = HOLD_CYCLES;
        src_no_gaps = 1'b1;
        repeat (30) send_message($urandom_range(1, 8), 1'b0, beats);
        src_no_gaps = 1'b0;
        settle();
    endtask

    task automatic test_random_stream();
        int sent;
        int phase;
        int len;
        int pick;
        int beats;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_BEATS) begin
            settle();
            case (phase % 4)
                0: write_seed(32'h0000_0000);
                1: write_seed(32'hffff_ffff);
                default: write_seed($urandom);
            endcase
            src_no_gaps  = ($urandom_range(0, 3) == 0);
            sink_no_gaps = ($urandom_range(0, 3) == 0);
            for (int m = 0; m < 20 && sent < RANDOM_BEATS; m++) begin
                pick = $urandom_range(0, 19);
                if (pick < 15)
                    len = $urandom_range(0, 8);
                else if (pick < 19)
                    len = $urandom_range(9, 24);
                else
                    len = $urandom_range(25, 64);
                send_message(len, $urandom_range(0, 3) == 0, beats);
                sent += beats;
            end
            phase++;
        end
        src_no_gaps  = 1'b0;
        sink_no_gaps = 1'b0;
    endtask

    initial begin
        aresetn      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        s_valid      <= 1'b0;
        s_data_byte  <= '0;
        s_byte_valid <= 1'b0;
        s_last       <= 1'b0;
        m_ready      <= 1'b0;
        src_no_gaps      = 1'b0;
        sink_no_gaps     = 1'b0;
        sink_hold_cycles = 0;
        seed_value       = '0;
        restart_message();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_message();
        test_short_lengths();
        test_ignored_beats();
        test_seed_update();
        test_backpressure();
        test_random_stream();
        settle();

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // result side: random stall per beat, one long hold on request
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = sink_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            if (sink_hold_cycles > 0) begin
                stall = sink_hold_cycles;
                sink_hold_cycles = 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        logic [31:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_hashes.size() == 0) begin
                report_mismatch($sformatf("unexpected hash beat %08h", m_hash_value));
            end else begin
                want = expected_hashes.pop_front();
                if (m_hash_value !== want)
                    report_mismatch($sformatf("hash_value got %08h, want %08h",
                                              m_hash_value, want));
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/m3h_pkg.sv
hw/rtl/m3h_front.sv
hw/rtl/m3h_queue.sv
hw/rtl/m3h_back.sv
hw/rtl/murmur3_32_string_hash_core.sv
tb/tb.sv
